// File: rtl/ltsq_pkg.sv
// Shared types, codes and constants of the locked task sequence queues.
`default_nettype none
package ltsq_pkg;

  // Default sizing, handed to the top-level parameters.
  localparam int MAX_QUEUES_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int HANDLE_BITS_DEF = 16;

  // Fixed field widths of the request and response items.
  localparam int ACTION_W   = 2;
  localparam int QID_W      = 8;
  localparam int HANDLE_W   = 16;
  localparam int STATUS_W   = 3;
  localparam int FREE_W     = 5;
  localparam int ACTIVE_W   = 4;
  localparam int LIMIT_W    = 5;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 32;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd0;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 5'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_QUEUES = 1'b0,
    CFG_QUEUE_LIMIT   = 1'b1
  } cfg_idx_e;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_TAKE   = 2'd1,
    ACT_UNLOCK = 2'd2,
    ACT_QUERY  = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_INVALID = 3'd2,
    ST_LOCKED  = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // latch request, start store read
    logic exec;     // apply request, load response register
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free; // response register empty or being drained
  } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/ltsq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ltsq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/ltsq_ctrl.sv
// Request sequencer: accept, then execute once the response register is free.
`default_nettype none
module ltsq_ctrl
  import ltsq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       req_valid_i,
  output logic            req_ready_o,
  input  wire dp_status_t dp_sts_i,
  output ctrl_cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold the read data until the response slot opens
        if (dp_sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/ltsq_dp.sv
// Queue pointers, lock bits, handle store and response register.
`default_nettype none
module ltsq_dp
  import ltsq_pkg::*;
#(
  parameter int MAX_QUEUES  = MAX_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ctrl_cmd_t             cmd_i,
  output dp_status_t                 sts_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [ACTION_W-1:0]   req_action_i,
  input  wire logic [QID_W-1:0]      req_qid_i,
  input  wire logic [HANDLE_W-1:0]   req_handle_i,
  output logic                       rsp_valid_o,
  input  wire logic                  rsp_ready_i,
  output logic [STATUS_W-1:0]        rsp_status_o,
  output logic [HANDLE_W-1:0]        rsp_task_o,
  output logic [FREE_W-1:0]          rsp_free_o,
  output logic                       rsp_task_ready_o
);

  localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = FW + 1;
  localparam int LW = (FW > LIMIT_W) ? FW : LIMIT_W;
  localparam int RAM_DEPTH = MAX_QUEUES * QUEUE_DEPTH;
  localparam int AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  // configuration
  logic [ACTIVE_W-1:0] active_q;
  logic [LIMIT_W-1:0]  limit_q;
  // per-queue state
  logic [HW-1:0] head_q [MAX_QUEUES];
  logic [FW-1:0] fill_q [MAX_QUEUES];
  logic          lock_q [MAX_QUEUES];
  // latched request
  logic [ACTION_W-1:0]    act_q;
  logic [QID_W-1:0]       qid_q;
  logic [HANDLE_BITS-1:0] handle_q;
  // response register
  logic                rsp_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [HANDLE_W-1:0] task_q;
  logic [FREE_W-1:0]   free_q;
  logic                tready_q;

  logic [QID_W-1:0]       act_cnt;
  logic [QID_W-1:0]       new_cnt;
  logic [LW-1:0]          lim;
  logic [QW-1:0]          in_idx;
  logic [QW-1:0]          qi;
  logic                   q_valid;
  logic [HW-1:0]          head_cur, head_n;
  logic [FW-1:0]          fill_cur, fill_n;
  logic                   lock_cur, lock_n;
  logic                   upd;
  logic [SW-1:0]          sum;
  logic [HW-1:0]          slot;
  logic [LW-1:0]          fill_l;
  logic [LW-1:0]          free_l;
  logic [AW-1:0]          raddr, waddr;
  logic                   ram_we;
  logic [HANDLE_BITS-1:0] rdata;
  logic [31:0]            h_in32, t_out32;
  logic [STATUS_W-1:0]    status_n;
  logic [HANDLE_W-1:0]    task_n;
  logic [FREE_W-1:0]      free_n;
  logic                   tready_n;

  // Saturate the active count and clamp the limit into 1..QUEUE_DEPTH.
  always_comb begin
    act_cnt = ({4'b0, active_q} > QID_W'(MAX_QUEUES)) ? QID_W'(MAX_QUEUES)
                                                      : {4'b0, active_q};
    new_cnt = ({4'b0, cfg_data_i[ACTIVE_W-1:0]} > QID_W'(MAX_QUEUES))
              ? QID_W'(MAX_QUEUES) : {4'b0, cfg_data_i[ACTIVE_W-1:0]};
    if (limit_q == '0) begin
      lim = LW'(1);
    end else if (LW'(limit_q) > LW'(QUEUE_DEPTH)) begin
      lim = LW'(QUEUE_DEPTH);
    end else begin
      lim = LW'(limit_q);
    end
  end

  // Keep array indexes in range for ids past the last queue.
  assign in_idx = (req_qid_i < QID_W'(MAX_QUEUES)) ? req_qid_i[QW-1:0] : '0;
  assign qi     = (qid_q < QID_W'(MAX_QUEUES)) ? qid_q[QW-1:0] : '0;
  assign q_valid = qid_q < act_cnt;

  assign h_in32 = {16'b0, req_handle_i};
  assign raddr  = AW'(in_idx) * AW'(QUEUE_DEPTH) + AW'(head_q[in_idx]);

  always_comb begin
    head_cur = head_q[qi];
    fill_cur = fill_q[qi];
    lock_cur = lock_q[qi];
    head_n   = head_cur;
    fill_n   = fill_cur;
    lock_n   = lock_cur;
    ram_we   = 1'b0;
    status_n = ST_OK;
    task_n   = '0;
    t_out32  = 32'(rdata);
    fill_l   = LW'(fill_cur);
    // tail slot, wrapped once around the ring
    sum      = SW'(head_cur) + SW'(fill_cur);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    slot  = sum[HW-1:0];
    waddr = AW'(qi) * AW'(QUEUE_DEPTH) + AW'(slot);
    case (act_q)
      ACT_ADD: begin
        if (fill_l >= lim) begin
          status_n = ST_FULL;
        end else begin
          ram_we = q_valid;
          fill_n = fill_cur + FW'(1);
        end
      end
      ACT_TAKE: begin
        if (lock_cur) begin
          status_n = ST_LOCKED;
        end else if (fill_cur == '0) begin
          status_n = ST_EMPTY;
        end else begin
          task_n = t_out32[HANDLE_W-1:0];
          sum    = SW'(head_cur) + SW'(1);
          if (sum >= SW'(QUEUE_DEPTH)) begin
            sum = '0;
          end
          head_n = sum[HW-1:0];
          fill_n = fill_cur - FW'(1);
          lock_n = (qi != '0);
        end
      end
      ACT_UNLOCK: lock_n = 1'b0;
      default: ;
    endcase
    free_l   = (LW'(fill_n) >= lim) ? '0 : lim - LW'(fill_n);
    free_n   = FREE_W'(free_l);
    tready_n = !lock_n && (fill_n != '0);
    upd      = cmd_i.exec && q_valid;
    if (!q_valid) begin
      status_n = ST_INVALID;
      task_n   = '0;
      free_n   = '0;
      tready_n = 1'b0;
    end
  end

  ltsq_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we && cmd_i.exec),
    .waddr_i (waddr),
    .wdata_i (handle_q),
    .re_i    (cmd_i.capture),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RESET;
      limit_q  <= LIMIT_RESET;
      for (int i = 0; i < MAX_QUEUES; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
        lock_q[i] <= 1'b0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_ACTIVE_QUEUES) begin
        active_q <= cfg_data_i[ACTIVE_W-1:0];
        // drop every queue that falls out of use
        for (int i = 0; i < MAX_QUEUES; i++) begin
          if (QID_W'(i) >= new_cnt) begin
            head_q[i] <= '0;
            fill_q[i] <= '0;
            lock_q[i] <= 1'b0;
          end
        end
      end else begin
        limit_q <= cfg_data_i[LIMIT_W-1:0];
      end
    end else if (upd) begin
      head_q[qi] <= head_n;
      fill_q[qi] <= fill_n;
      lock_q[qi] <= lock_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q    <= req_action_i;
      qid_q    <= req_qid_i;
      handle_q <= h_in32[HANDLE_BITS-1:0];
    end
    if (cmd_i.exec) begin
      status_q <= status_n;
      task_q   <= task_n;
      free_q   <= free_n;
      tready_q <= tready_n;
    end
  end

  assign sts_o.out_free  = !rsp_valid_q || rsp_ready_i;
  assign rsp_valid_o      = rsp_valid_q;
  assign rsp_status_o     = status_q;
  assign rsp_task_o       = task_q;
  assign rsp_free_o       = free_q;
  assign rsp_task_ready_o = tready_q;

`ifndef SYNTHESIS
  // never overwrite a response that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |-> (!rsp_valid_q || rsp_ready_i))
    else $error("response overwritten before it was taken");

  // the shared pool never locks
  assert property (@(posedge clk_i) disable iff (!rst_ni) !lock_q[0])
    else $error("queue 0 locked");

  // fill of the addressed queue stays within the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |-> (fill_n <= FW'(QUEUE_DEPTH)))
    else $error("queue fill beyond depth");

  // a successful take leaves one entry fewer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd && act_q == ACT_TAKE && status_n == ST_OK) |=> fill_q[$past(qi)] ==
      $past(fill_cur) - FW'(1))
    else $error("take did not pop an entry");
`endif

endmodule
`default_nettype wire

// File: rtl/locked_task_sequence_queues_core.sv
// Top level of the locked task sequence queues: stream ports and config port.
// Sequence: the store read starts at the edge that accepts a request; once the response
//   register is free, the queue is updated and the response register is loaded.
// Requests: a new request waits until the last one has executed, as the handle store
//   and per-queue pointers are read, then written; longer while the response register stays full.
// Reset: asynchronous, active low; all queues empty and unlocked, active_queues 0,
//   queue_limit 16. The handle store is not cleared; only written slots are returned.
`default_nettype none
module locked_task_sequence_queues_core
  import ltsq_pkg::*;
#(
  parameter int MAX_QUEUES  = MAX_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // request stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // queue_id[7:0], task_handle[23:8]
  input  wire logic [ACTION_W-1:0]   s_axis_tuser,  // action[1:0]
  // response stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]       m_axis_tdata   // status[2:0], task_out[18:3],
                                                    // free_spaces[23:19], task_ready[24]
);

  ctrl_cmd_t           cmd;
  dp_status_t          dp_sts;
  logic [STATUS_W-1:0] rsp_status;
  logic [HANDLE_W-1:0] rsp_task;
  logic [FREE_W-1:0]   rsp_free;
  logic                rsp_task_ready;

  // Sequencer: takes one request, waits for a free response slot, executes.
  ltsq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .dp_sts_i    (dp_sts),
    .cmd_o       (cmd)
  );

  // Datapath: per-queue pointers and locks, handle store, response register.
  ltsq_dp #(
    .MAX_QUEUES  (MAX_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (dp_sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .req_action_i     (s_axis_tuser),
    .req_qid_i        (s_axis_tdata[QID_W-1:0]),
    .req_handle_i     (s_axis_tdata[QID_W+HANDLE_W-1:QID_W]),
    .rsp_valid_o      (m_axis_tvalid),
    .rsp_ready_i      (m_axis_tready),
    .rsp_status_o     (rsp_status),
    .rsp_task_o       (rsp_task),
    .rsp_free_o       (rsp_free),
    .rsp_task_ready_o (rsp_task_ready)
  );

  // Pack the response fields from the lowest bit up; pad to whole bytes.
  assign m_axis_tdata = {7'b0, rsp_task_ready, rsp_free, rsp_task, rsp_status};

endmodule
`default_nettype wire

// File: sim/locked_task_sequence_queues_core_tb.sv
// Testbench of the locked task sequence queues core: directed and random requests.
`timescale 1ns / 1ps
module locked_task_sequence_queues_core_tb;
  import ltsq_pkg::*;

  localparam int NUM_Q        = MAX_QUEUES_DEF;
  localparam int DEPTH        = QUEUE_DEPTH_DEF;
  localparam int HEAD_W       = $clog2(DEPTH);
  localparam int QUIET_LIMIT  = 2000;  // cycles without any handshake before giving up
  localparam int DRAIN_CYCLES = 4;     // settling margin after the last response
  localparam int MAX_REPORTS  = 10;

  // Response fields, packed to line up with m_axis_tdata from bit 0 upward.
  typedef struct packed {
    logic                task_ready;
    logic [FREE_W-1:0]   free_spaces;
    logic [HANDLE_W-1:0] task_out;
    status_e             status;
  } response_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;  // queue_id[7:0], task_handle[23:8]
  logic [ACTION_W-1:0]   s_axis_tuser  = '0;  // action[1:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;        // status[2:0], task_out[18:3],
                                              // free_spaces[23:19], task_ready[24]

  locked_task_sequence_queues_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the queue state and the two registers.
  logic [HANDLE_W-1:0] q_store [NUM_Q][DEPTH];
  logic [HEAD_W-1:0]   q_head  [NUM_Q];
  logic [FREE_W-1:0]   q_fill  [NUM_Q];
  logic                q_lock  [NUM_Q];
  logic [ACTIVE_W-1:0] active_reg = ACTIVE_RESET;
  logic [LIMIT_W-1:0]  limit_reg  = LIMIT_RESET;

  response_t pending_responses [$];
  int        mismatch_count = 0;
  int        quiet_cycles   = 0;
  bit        idle_on        = 1'b1;  // random gaps on both sides while set

  // Handshakes sampled mid-cycle; they take effect at the following rising edge.
  logic                 req_taken = 1'b0;
  logic                 rsp_taken = 1'b0;
  logic [M_TDATA_W-1:0] rsp_word  = '0;

  initial begin
    for (int q = 0; q < NUM_Q; q++) begin
      q_head[q] = '0;
      q_fill[q] = '0;
      q_lock[q] = 1'b0;
    end
  end

  always @(negedge clk_i) begin
    req_taken = s_axis_tvalid && s_axis_tready;
    rsp_taken = m_axis_tvalid && m_axis_tready;
    rsp_word  = m_axis_tdata;
  end

  // Stall the response side about a third of the time while idling is on.
  always @(posedge clk_i) begin
    m_axis_tready <= !(idle_on && $urandom_range(99) < 35);
  end

  function automatic int queues_in_use();
    return (active_reg > NUM_Q) ? NUM_Q : int'(active_reg);
  endfunction

  function automatic int capacity_in_use();
    if (limit_reg == 0) return 1;
    return (limit_reg > DEPTH) ? DEPTH : int'(limit_reg);
  endfunction

  // Apply one request to the shadow state and return the response it should give.
  function automatic response_t queue_response(action_e act, logic [QID_W-1:0] qid,
                                               logic [HANDLE_W-1:0] handle);
    response_t rsp;
    int        slot;
    int        cap;
    rsp        = '0;
    rsp.status = ST_INVALID;
    // Out-of-range id: all other fields zero, nothing touched.
    if (qid >= queues_in_use()) return rsp;
    cap        = capacity_in_use();
    rsp.status = ST_OK;
    case (act)
      ACT_ADD: begin
        // Add ignores the lock; a lowered limit can leave fill above capacity.
        if (q_fill[qid] >= cap) begin
          rsp.status = ST_FULL;
        end else begin
          slot = (q_head[qid] + q_fill[qid]) % DEPTH;
          q_store[qid][slot] = handle;
          q_fill[qid]++;
        end
      end
      ACT_TAKE: begin
        // Lock wins over empty.
        if (q_lock[qid]) begin
          rsp.status = ST_LOCKED;
        end else if (q_fill[qid] == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          rsp.task_out = q_store[qid][q_head[qid]];
          q_head[qid]++;
          q_fill[qid]--;
          // The shared pool never locks.
          if (qid != 0) q_lock[qid] = 1'b1;
        end
      end
      ACT_UNLOCK: q_lock[qid] = 1'b0;
      default: ;
    endcase
    rsp.free_spaces = (q_fill[qid] >= cap) ? '0 : FREE_W'(cap - q_fill[qid]);
    rsp.task_ready  = !q_lock[qid] && (q_fill[qid] != 0);
    return rsp;
  endfunction

  // Compare each accepted response with the oldest expectation.
  always @(posedge clk_i) begin : check_responses
    response_t got;
    response_t want;
    if (rsp_taken) begin
      got = response_t'(rsp_word[$bits(response_t)-1:0]);
      if (pending_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected response %h with none pending", rsp_word);
      end else begin
        want = pending_responses.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch exp/got: status %0d/%0d task %h/%h free %0d/%0d ready %0d/%0d",
                     want.status, got.status, want.task_out, got.task_out,
                     want.free_spaces, got.free_spaces, want.task_ready, got.task_ready);
        end
      end
    end
  end

  // Abort when no request, response or register write moves for too long.
  always @(posedge clk_i) begin
    if (req_taken || rsp_taken || cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Offer one request, with a random gap first, and hold it until accepted.
  task automatic send_request(action_e act, logic [QID_W-1:0] qid,
                              logic [HANDLE_W-1:0] handle);
    while (idle_on && $urandom_range(99) < 35) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {handle, qid};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!req_taken);
    pending_responses.push_back(queue_response(act, qid, handle));
  endtask

  // Drop valid, let every pending response drain, then let the pipeline settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one register once the block is idle; mirror the effect in the shadow state.
  task automatic write_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ACTIVE_QUEUES) begin
      active_reg = value[ACTIVE_W-1:0];
      // Queues beyond the new count come back empty and unlocked.
      for (int q = queues_in_use(); q < NUM_Q; q++) begin
        q_head[q] = '0;
        q_fill[q] = '0;
        q_lock[q] = 1'b0;
      end
    end else begin
      limit_reg = value;
    end
    @(posedge clk_i);
  endtask

  // Out of reset no queue is set up, so every id is rejected.
  task automatic test_reset_state();
    send_request(ACT_ADD, 8'd0, 16'h0000);
    send_request(ACT_QUERY, 8'd0, 16'hFFFF);
  endtask

  // FIFO order, full, lock after take, unlock, empty, lock-before-empty, shared pool.
  task automatic test_fifo_and_lock();
    write_register(CFG_ACTIVE_QUEUES, 5'd15);  // saturates to the queue count
    write_register(CFG_QUEUE_LIMIT, 5'd3);
    send_request(ACT_ADD, 8'd1, 16'h0000);
    send_request(ACT_ADD, 8'd1, 16'hFFFF);
    send_request(ACT_ADD, 8'd1, 16'hA5A5);
    send_request(ACT_ADD, 8'd1, 16'h5A5A);     // full
    send_request(ACT_TAKE, 8'd1, 16'h0000);    // pops oldest, locks
    send_request(ACT_TAKE, 8'd1, 16'h0000);    // locked
    send_request(ACT_UNLOCK, 8'd1, 16'h0000);
    send_request(ACT_UNLOCK, 8'd1, 16'h0000);  // already unlocked
    send_request(ACT_TAKE, 8'd2, 16'h0000);    // empty
    send_request(ACT_ADD, 8'd3, 16'h1234);
    send_request(ACT_TAKE, 8'd3, 16'h0000);
    send_request(ACT_TAKE, 8'd3, 16'h0000);    // locked and empty: lock reported
    send_request(ACT_ADD, 8'd0, 16'hABCD);
    send_request(ACT_ADD, 8'd0, 16'h0001);
    send_request(ACT_TAKE, 8'd0, 16'h0000);
    send_request(ACT_TAKE, 8'd0, 16'h0000);    // pool stays unlocked
    send_request(ACT_ADD, 8'd8, 16'h7777);     // first invalid id
    send_request(ACT_TAKE, 8'hFF, 16'h0000);   // top invalid id
  endtask

  // Limit below fill, limit of zero, limit above depth.
  task automatic test_limits();
    write_register(CFG_QUEUE_LIMIT, 5'd1);
    send_request(ACT_QUERY, 8'd1, 16'h0000);   // two held, counts as full
    send_request(ACT_TAKE, 8'd1, 16'h0000);    // held entries still come out
    write_register(CFG_QUEUE_LIMIT, 5'd0);
    send_request(ACT_ADD, 8'd2, 16'h0F0F);
    send_request(ACT_ADD, 8'd2, 16'hF0F0);     // zero acts as one
    write_register(CFG_QUEUE_LIMIT, 5'd31);
    send_request(ACT_QUERY, 8'd2, 16'h0000);
  endtask

  // Shrinking the active count clears the queues that drop out.
  task automatic test_active_count();
    write_register(CFG_ACTIVE_QUEUES, 5'd2);
    send_request(ACT_QUERY, 8'd1, 16'h0000);
    send_request(ACT_QUERY, 8'd2, 16'h0000);
    write_register(CFG_ACTIVE_QUEUES, 5'd8);
    send_request(ACT_QUERY, 8'd2, 16'h0000);   // comes back fresh
  endtask

  // One phase of random traffic under a fixed register setting.
  task automatic run_random_phase(int count, logic [CFG_DATA_W-1:0] active_val,
                                  logic [CFG_DATA_W-1:0] limit_val, bit calm);
    int                  pick;
    action_e             act;
    logic [QID_W-1:0]    qid;
    logic [HANDLE_W-1:0] handle;
    write_register(CFG_ACTIVE_QUEUES, active_val);
    write_register(CFG_QUEUE_LIMIT, limit_val);
    idle_on = !calm;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 40)      act = ACT_ADD;
      else if (pick < 70) act = ACT_TAKE;
      else if (pick < 85) act = ACT_UNLOCK;
      else                act = ACT_QUERY;
      // Mostly live queues; the rest spread over the whole id range.
      if (queues_in_use() > 0 && $urandom_range(99) < 85)
        qid = QID_W'($urandom_range(queues_in_use() - 1));
      else
        qid = QID_W'($urandom_range(255));
      handle = HANDLE_W'($urandom);
      send_request(act, qid, handle);
    end
    wait_idle();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    run_random_phase(300, 5'd8, 5'd16, 1'b1);   // long stretch with no gaps
    run_random_phase(250, 5'd31, 5'd31, 1'b0);  // both registers saturate
    run_random_phase(200, 5'd1, 5'd1, 1'b0);    // smallest setting
    run_random_phase(200, 5'd8, 5'd0, 1'b0);
    repeat (4) begin
      run_random_phase(140, CFG_DATA_W'($urandom_range(31)),
                       CFG_DATA_W'($urandom_range(31)), 1'b0);
    end
  endtask

  initial begin
    // Hold reset low, then release it at a rising edge.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_fifo_and_lock();
    test_limits();
    test_active_count();
    test_random_traffic();

    wait_idle();
    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ltsq_pkg.sv
rtl/ltsq_ram.sv
rtl/ltsq_ctrl.sv
rtl/ltsq_dp.sv
rtl/locked_task_sequence_queues_core.sv
sim/locked_task_sequence_queues_core_tb.sv
